FILE: design/ffha_pkg.sv
// Shared constants and helpers for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
   localparam int HEAP_BYTES_DEF    = 8192;
   localparam int HEADER_BYTES_DEF  = 16;
   localparam int GRANULE_BYTES_DEF = 8;

   localparam logic       MODE_ALLOC = 1'b0;
   localparam logic       MODE_FREE  = 1'b1;

   localparam logic [2:0] ST_ALLOCATED    = 3'd0;
   localparam logic [2:0] ST_NO_FIT       = 3'd1;
   localparam logic [2:0] ST_FREED        = 3'd2;
   localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
   localparam logic [2:0] ST_INVALID      = 3'd4;

   localparam logic [0:0] CSR_HEAP_BASE = 1'd0;

   // Width needed to hold values 0..n-1 (at least one bit).
   function automatic int clog2_min1(input int n);
      int r;
      r = $clog2(n);
      return (r < 1) ? 1 : r;
   endfunction
endpackage

FILE: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
`timescale 1ns / 1ps
//
//  channel   ports                                         handshake
//  request   req_mode, req_alloc_size, req_free_address     start & !busy
//  result    rsp_status, rsp_data_address                   rsp_valid, one cycle
//  config    csr_psel/penable/pwrite/paddr/pwdata/prdata    APB, pready tied high
//
// Block headers live in one memory indexed by granule: {start, free, length},
// read through a register. Each step reads and writes that memory at most once.
// An allocate is accepted, visits blocks in turn from granule zero, writes a
// split remainder if there is one and then gives the result. A free divides
// the offset, checks the header, merges each free following block, writes
// back, walks backward one granule at a time to find the previous block (up to
// the heap size in granules) and merges a free previous block, then gives the
// result. After reset a clearing pass over all NUM_GRAN granules keeps busy
// high. Results cannot be stalled.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
   parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [15:0] req_alloc_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_data_address,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int NUM_GRAN = HEAP_BYTES / GRANULE_BYTES;
   localparam int HDR_GRAN = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
   localparam int GW       = ffha_pkg::clog2_min1(NUM_GRAN);
   localparam int LW       = GW + 1;
   localparam int EW       = LW + 2;
   localparam int SPLIT_MIN = 2 * HDR_GRAN + 1;
   localparam int HB_BYTES  = HDR_GRAN * GRANULE_BYTES;
   // divide by the granule through a reciprocal: dividends stay below 2^21
   // (rounded sizes need 17 bits, in-heap offsets at most 20)
   localparam int DVW = 21;
   localparam int RS  = DVW + 6;
   localparam int RW  = RS + 1;
   localparam longint RCP = ((longint'(1) << RS) + longint'(GRANULE_BYTES) - 1)
                            / longint'(GRANULE_BYTES);
   localparam logic [1:0] CSR_ADDR_BASE = {ffha_pkg::CSR_HEAP_BASE, 1'b0};

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_ARD     = 4'd2;
   localparam logic [3:0] S_AEVAL   = 4'd3;
   localparam logic [3:0] S_ASPLIT  = 4'd4;
   localparam logic [3:0] S_FCHK    = 4'd5;
   localparam logic [3:0] S_MNXT    = 4'd6;
   localparam logic [3:0] S_MEVAL   = 4'd7;
   localparam logic [3:0] S_MKILL   = 4'd8;
   localparam logic [3:0] S_MWB     = 4'd9;
   localparam logic [3:0] S_PSCAN   = 4'd10;
   localparam logic [3:0] S_PEVAL   = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;
   localparam logic [3:0] S_DIV     = 4'd13;

   // header memory: {start, free, length}
   logic [EW-1:0] mem [NUM_GRAN];
   logic [EW-1:0] rd_ff;
   logic          we;
   logic [GW-1:0] waddr, raddr;
   logic [EW-1:0] wdata;

   logic [3:0]    st_ff, st_in;
   logic [31:0]   base_ff;
   logic [GW-1:0] g_ff, g_in;        // current block
   logic [GW-1:0] p_ff, p_in;        // scan pointer
   logic [LW-1:0] len_ff, len_in;    // length of current block
   logic [LW-1:0] rq_ff, rq_in;      // requested granules
   logic [2:0]    sts_ff, sts_in;
   logic [31:0]   dat_ff, dat_in;
   logic [31:0]   q_ff, q_in;        // offset past the first header
   logic          ok_ff, ok_in;      // offset in range

   logic [LW:0]   nxt_w;
   logic          rd_start, rd_free;
   logic [LW-1:0] rd_len;

   // quotient by the granule size
   function automatic logic [DVW-1:0] gran_div(input logic [DVW-1:0] x);
      logic [DVW+RW-1:0] prod;
      prod = {{RW{1'b0}}, x} * (DVW+RW)'(RCP);
      return prod[RS +: DVW];
   endfunction

   assign rd_start = rd_ff[EW-1];
   assign rd_free  = rd_ff[EW-2];
   assign rd_len   = rd_ff[LW-1:0];
   assign nxt_w    = {1'b0, {(LW-GW){1'b0}}, g_ff} + (LW+1)'(HDR_GRAN)
                     + {1'b0, len_ff};

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_BASE) ? base_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_BASE) begin
         base_ff <= csr_pwdata;
      end
   end

   assign busy             = (st_ff != S_IDLE);
   assign rsp_valid        = (st_ff == S_DONE);
   assign rsp_status       = sts_ff;
   assign rsp_data_address = dat_ff;

   // control and datapath
   always_comb begin
      logic [31:0]    off;
      logic [LW:0]    rq_w;
      logic [DVW-1:0] rq_d;
      logic [DVW-1:0] xd;
      logic [DVW-1:0] qd;
      st_in = st_ff; g_in = g_ff; p_in = p_ff; len_in = len_ff; rq_in = rq_ff;
      sts_in = sts_ff; dat_in = dat_ff; q_in = q_ff; ok_in = ok_ff;
      we = 1'b0; waddr = p_ff; wdata = '0; raddr = p_ff;
      off = req_free_address - base_ff;
      rq_w = '0; rq_d = '0; xd = '0; qd = '0;
      unique case (st_ff)
         S_CLEAR: begin
            // sweep memory to one free block at granule zero
            we = 1'b1; waddr = p_ff;
            wdata = (p_ff == '0) ? {1'b1, 1'b1, LW'(NUM_GRAN - HDR_GRAN)} : '0;
            p_in = p_ff + 1'b1;
            if (p_ff == GW'(NUM_GRAN - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_mode == ffha_pkg::MODE_ALLOC) begin
                  rq_d = gran_div(DVW'(req_alloc_size) + DVW'(GRANULE_BYTES - 1));
                  if (rq_d > DVW'(NUM_GRAN)) begin
                     sts_in = ffha_pkg::ST_NO_FIT; dat_in = '0; st_in = S_DONE;
                  end else begin
                     rq_in = rq_d[LW-1:0];
                     p_in = '0; g_in = '0; raddr = '0; st_in = S_AEVAL;
                  end
               end else begin
                  sts_in = ffha_pkg::ST_INVALID; dat_in = '0;
                  ok_in = (off >= 32'(HB_BYTES));
                  q_in = off - 32'(HB_BYTES);
                  st_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // turn the offset into a granule index, drop misaligned or outside
            xd = q_ff[DVW-1:0];
            qd = gran_div(xd);
            p_in = qd[GW-1:0]; raddr = qd[GW-1:0]; st_in = S_FCHK;
            if (!ok_ff || q_ff >= 32'(NUM_GRAN * GRANULE_BYTES)
                || xd != DVW'(qd * DVW'(GRANULE_BYTES))) st_in = S_DONE;
         end
         S_ARD: begin
            raddr = p_ff; st_in = S_AEVAL;
         end
         S_AEVAL: begin
            // examine block at p
            g_in = p_ff; len_in = rd_len;
            if (!rd_start) begin
               sts_in = ffha_pkg::ST_NO_FIT; dat_in = '0; st_in = S_DONE;
            end else if (rd_free && rd_len >= rq_ff) begin
               sts_in = ffha_pkg::ST_ALLOCATED;
               dat_in = base_ff + 32'((32'(p_ff) + 32'(HDR_GRAN)) * 32'(GRANULE_BYTES));
               we = 1'b1; waddr = p_ff;
               if ({1'b0, rd_len} > {1'b0, rq_ff} + (LW+1)'(SPLIT_MIN)) begin
                  wdata = {1'b1, 1'b0, rq_ff};
                  st_in = S_ASPLIT;
               end else begin
                  wdata = {1'b1, 1'b0, rd_len};
                  st_in = S_DONE;
               end
            end else begin
               rq_w = {1'b0, {(LW-GW){1'b0}}, p_ff} + (LW+1)'(HDR_GRAN) + {1'b0, rd_len};
               if (rq_w >= (LW+1)'(NUM_GRAN)) begin
                  sts_in = ffha_pkg::ST_NO_FIT; dat_in = '0; st_in = S_DONE;
               end else begin
                  p_in = rq_w[GW-1:0]; st_in = S_ARD;
               end
            end
         end
         S_ASPLIT: begin
            // write the free remainder
            rq_w = {1'b0, {(LW-GW){1'b0}}, g_ff} + (LW+1)'(HDR_GRAN) + {1'b0, rq_ff};
            we = 1'b1; waddr = rq_w[GW-1:0];
            wdata = {1'b1, 1'b1, LW'({1'b0, len_ff} - {1'b0, rq_ff} - (LW+1)'(HDR_GRAN))};
            st_in = S_DONE;
         end
         S_FCHK: begin
            g_in = p_ff; len_in = rd_len;
            if (!rd_start) begin
               st_in = S_DONE;
            end else if (rd_free) begin
               sts_in = ffha_pkg::ST_ALREADY_FREE; st_in = S_DONE;
            end else begin
               sts_in = ffha_pkg::ST_FREED;
               we = 1'b1; waddr = p_ff; wdata = {1'b1, 1'b1, rd_len};
               st_in = S_MNXT;
            end
         end
         S_MNXT: begin
            // read the block after g
            if (nxt_w >= (LW+1)'(NUM_GRAN)) begin
               st_in = S_MWB;
            end else begin
               p_in = nxt_w[GW-1:0]; raddr = nxt_w[GW-1:0]; st_in = S_MEVAL;
            end
         end
         S_MEVAL: begin
            if (rd_start && rd_free) begin
               len_in = LW'({1'b0, len_ff} + (LW+1)'(HDR_GRAN) + {1'b0, rd_len});
               we = 1'b1; waddr = p_ff; wdata = '0;
               st_in = S_MNXT;
            end else begin
               st_in = S_MWB;
            end
         end
         S_MWB: begin
            // write merged length, then look backward
            we = 1'b1; waddr = g_ff; wdata = {1'b1, 1'b1, len_ff};
            if (g_ff == '0) begin
               st_in = S_DONE;
            end else begin
               p_in = g_ff - 1'b1; raddr = g_ff - 1'b1; st_in = S_PEVAL;
            end
         end
         S_PSCAN: begin
            raddr = p_ff; st_in = S_PEVAL;
         end
         S_PEVAL: begin
            if (rd_start || p_ff == '0) begin
               if (rd_free) begin
                  // previous block is free: absorb g into it
                  we = 1'b1; waddr = g_ff; wdata = '0;
                  g_in = p_ff;
                  len_in = LW'({1'b0, rd_len} + (LW+1)'(HDR_GRAN) + {1'b0, len_ff});
                  st_in = S_MKILL;
               end else begin
                  st_in = S_DONE;
               end
            end else begin
               p_in = p_ff - 1'b1; raddr = p_ff - 1'b1; st_in = S_PEVAL;
            end
         end
         S_MKILL: begin
            // continue forward merge from the new block
            st_in = S_MNXT;
         end
         S_DONE: begin
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         p_ff  <= '0;
      end else begin
         st_ff <= st_in;
         p_ff  <= p_in;
      end
      g_ff <= g_in; len_ff <= len_in; rq_ff <= rq_in; sts_ff <= sts_in;
      dat_ff <= dat_in; q_ff <= q_in; ok_ff <= ok_in;
   end

   // a result always carries a defined status
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ffha_pkg::ST_INVALID))
      else $error("bad status");
   // failed requests return a zero address
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffha_pkg::ST_ALLOCATED |-> rsp_data_address == 32'd0)
      else $error("nonzero address");
   // one result per item, then back to idle
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("double result");
endmodule
